// ===== hdl/efr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package efr_pkg;

  localparam int unsigned EFR_MAX_PAYLOAD = 256;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned COUNT_W         = 9;
  localparam int unsigned CFG_IDX_W       = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_MARKER   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_MARKER = 2'd2;

  localparam logic [BYTE_W-1:0] START_MARKER_RST  = 8'd126;
  localparam logic [BYTE_W-1:0] STOP_MARKER_RST   = 8'd127;
  localparam logic [BYTE_W-1:0] ESCAPE_MARKER_RST = 8'd125;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_FRAME,
    MODE_ESCAPED
  } rx_mode_e;

  typedef enum logic [1:0] {
    EV_BYTE     = 2'd0,
    EV_END      = 2'd1,
    EV_RESTART  = 2'd2,
    EV_OVERFLOW = 2'd3
  } event_kind_e;

  typedef struct packed {
    event_kind_e         kind;
    logic [BYTE_W-1:0]   data;
    logic [COUNT_W-1:0]  count;
  } event_t;

endpackage
`default_nettype wire

// ===== hdl/efr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module efr_front
  import efr_pkg::*;
#(
  parameter int unsigned MaxPayload = EFR_MAX_PAYLOAD
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [BYTE_W-1:0]    cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [BYTE_W-1:0]    rx_byte_i,
  output logic                      ev_valid_o,
  output event_t                    ev_o,
  input  wire logic                 ev_ready_i
);

  localparam int unsigned CntW = $clog2(MaxPayload + 1);
  localparam int unsigned ExtW = (CntW > COUNT_W) ? CntW : COUNT_W;

  logic [BYTE_W-1:0] start_q, stop_q, escape_q;
  rx_mode_e          mode_q, mode_d;
  logic [CntW-1:0]   cnt_q, cnt_d, cnt_inc;
  logic [ExtW-1:0]   cnt_ext, inc_ext;
  logic              accept, has_event, take;

  assign cnt_inc    = cnt_q + CntW'(1);
  assign cnt_ext    = ExtW'(cnt_q);
  assign inc_ext    = ExtW'(cnt_inc);
  assign in_ready_o = ev_ready_i;
  assign accept     = in_valid_i & ev_ready_i;
  assign ev_valid_o = in_valid_i & has_event;

  always_comb begin
    mode_d     = mode_q;
    cnt_d      = cnt_q;
    has_event  = 1'b0;
    take       = 1'b0;
    ev_o.kind  = EV_BYTE;
    ev_o.data  = '0;
    ev_o.count = cnt_ext[COUNT_W-1:0];
    case (mode_q)
      MODE_ESCAPED: begin
        take = 1'b1;
      end
      MODE_FRAME: begin
        if (rx_byte_i == stop_q) begin
          mode_d    = MODE_IDLE;
          cnt_d     = '0;
          has_event = 1'b1;
          ev_o.kind = EV_END;
        end else if (rx_byte_i == start_q) begin
          cnt_d     = '0;
          has_event = 1'b1;
          ev_o.kind = EV_RESTART;
        end else if (rx_byte_i == escape_q) begin
          mode_d = MODE_ESCAPED;
        end else begin
          take = 1'b1;
        end
      end
      default: begin
        if (rx_byte_i == start_q) begin
          mode_d = MODE_FRAME;
          cnt_d  = '0;
        end
      end
    endcase
    if (take) begin
      has_event = 1'b1;
      if (cnt_q >= CntW'(MaxPayload)) begin
        mode_d    = MODE_IDLE;
        cnt_d     = '0;
        ev_o.kind = EV_OVERFLOW;
      end else begin
        mode_d     = MODE_FRAME;
        cnt_d      = cnt_inc;
        ev_o.data  = rx_byte_i;
        ev_o.count = inc_ext[COUNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      cnt_q  <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= START_MARKER_RST;
      stop_q   <= STOP_MARKER_RST;
      escape_q <= ESCAPE_MARKER_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_START_MARKER:  start_q  <= cfg_data_i;
        CFG_STOP_MARKER:   stop_q   <= cfg_data_i;
        CFG_ESCAPE_MARKER: escape_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/efr_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module efr_queue
  import efr_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_valid_i,
  output logic        push_ready_o,
  input  wire event_t push_data_i,
  output logic        pop_valid_o,
  input  wire logic   pop_ready_i,
  output event_t      pop_data_o
);

  event_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       push, pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/escaped_frame_receiver_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Direction | Handshake                   | Payload
// config   | in        | cfg_valid_i / cfg_ready_o   | cfg_index_i, cfg_data_i
// rx bytes | in        | in_valid_i / in_ready_o     | rx_byte_i
// events   | out       | out_valid_o / out_ready_i   | event_kind_o, payload_byte_o,
//          |           |                             | payload_count_o
// One byte is accepted every cycle while the two-entry event queue has room.
// An event is pushed into the event queue as its byte is accepted; the output is driven from the queue registers.
// The decode step holds the frame state and decides combinationally.
// Reset restores the marker values and returns the receiver to idle.
// Output stalls fill the queue; input stalls only once it holds two events.
module escaped_frame_receiver_top
  import efr_pkg::*;
#(
  parameter int unsigned MaxPayload = EFR_MAX_PAYLOAD
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [BYTE_W-1:0]    cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [BYTE_W-1:0]    rx_byte_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [1:0]                event_kind_o,
  output logic [BYTE_W-1:0]         payload_byte_o,
  output logic [COUNT_W-1:0]        payload_count_o
);

  logic   ev_valid, ev_ready;
  event_t ev, out_ev;

  assign cfg_ready_o     = 1'b1;
  assign event_kind_o    = out_ev.kind;
  assign payload_byte_o  = out_ev.data;
  assign payload_count_o = out_ev.count;

  efr_front #(
    .MaxPayload(MaxPayload)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .ev_valid_o (ev_valid),
    .ev_o       (ev),
    .ev_ready_i (ev_ready)
  );

  efr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(ev_valid),
    .push_ready_o(ev_ready),
    .push_data_i (ev),
    .pop_valid_o (out_valid_o),
    .pop_ready_i (out_ready_i),
    .pop_data_o  (out_ev)
  );

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import efr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_SHOWN   = 100;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [BYTE_W-1:0]    rx_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           event_kind;
  logic [BYTE_W-1:0]    payload_byte;
  logic [COUNT_W-1:0]   payload_count;

  logic [BYTE_W-1:0] pending_bytes[$];
  event_t            expected_events[$];
  event_t            want;

  logic [BYTE_W-1:0] open_mark   = START_MARKER_RST;
  logic [BYTE_W-1:0] close_mark  = STOP_MARKER_RST;
  logic [BYTE_W-1:0] escape_byte = ESCAPE_MARKER_RST;
  rx_mode_e          frame_state = MODE_IDLE;
  int unsigned       frame_len = 0;

  int unsigned bytes_planned = 0;
  int unsigned events_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  bit          send_steady = 1'b0;
  bit          recv_steady = 1'b0;

  escaped_frame_receiver_top uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .event_kind_o   (event_kind),
    .payload_byte_o (payload_byte),
    .payload_count_o(payload_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void decode_rx_byte(input logic [BYTE_W-1:0] b);
    int unsigned held;
    bit          as_payload;
    event_t      ev;
    held       = frame_len;
    as_payload = 1'b0;
    ev.kind    = EV_BYTE;
    ev.data    = '0;
    ev.count   = COUNT_W'(held);
    if (frame_state == MODE_ESCAPED) begin
      as_payload = 1'b1;
    end else if (frame_state != MODE_FRAME) begin
      if (b == open_mark) begin
        frame_state = MODE_FRAME;
        frame_len   = 0;
      end
    end else if (b == close_mark) begin
      frame_state = MODE_IDLE;
      frame_len   = 0;
      ev.kind     = EV_END;
      expected_events.push_back(ev);
    end else if (b == open_mark) begin
      frame_len = 0;
      ev.kind   = EV_RESTART;
      expected_events.push_back(ev);
    end else if (b == escape_byte) begin
      frame_state = MODE_ESCAPED;
    end else begin
      as_payload = 1'b1;
    end
    if (as_payload) begin
      if (held >= EFR_MAX_PAYLOAD) begin
        frame_state = MODE_IDLE;
        frame_len   = 0;
        ev.kind     = EV_OVERFLOW;
      end else begin
        frame_state = MODE_FRAME;
        frame_len   = held + 1;
        ev.data     = b;
        ev.count    = COUNT_W'(frame_len);
      end
      expected_events.push_back(ev);
    end
  endfunction

  task automatic flag_mismatch(input string what);
    if (mismatches < MAX_SHOWN) begin
      $display("mismatch at event %0d: %s", events_seen, what);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        decode_rx_byte(rx_byte);
        send_wait = send_steady ? 0 : $urandom_range(0, 14);
      end
      if (!in_valid || in_ready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          in_valid <= 1'b1;
          rx_byte  <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          flag_mismatch($sformatf("unexpected transaction kind %0d byte %0h count %0d",
                                  event_kind, payload_byte, payload_count));
        end else begin
          want = expected_events.pop_front();
          if (event_kind != want.kind) begin
            flag_mismatch($sformatf("kind %0d, expected %0d", event_kind, want.kind));
          end
          if (payload_byte != want.data) begin
            flag_mismatch($sformatf("byte %0h, expected %0h", payload_byte, want.data));
          end
          if (payload_count != want.count) begin
            flag_mismatch($sformatf("count %0d, expected %0d", payload_count, want.count));
          end
        end
        events_seen++;
        recv_wait = recv_steady ? 0 : $urandom_range(0, 14);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("escaped_frame_receiver_top regression: fail");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_START_MARKER:  open_mark   = val;
      CFG_STOP_MARKER:   close_mark  = val;
      CFG_ESCAPE_MARKER: escape_byte = val;
      default: ;
    endcase
  endtask

  task automatic settle();
    while (pending_bytes.size() != 0 || in_valid || expected_events.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(posedge clk);
    send_steady = ($urandom_range(0, 3) == 0);
    recv_steady = ($urandom_range(0, 3) == 0);
  endtask

  task automatic queue_byte(input logic [BYTE_W-1:0] b);
    pending_bytes.push_back(b);
    bytes_planned++;
  endtask

  function automatic logic [BYTE_W-1:0] content_byte();
    case ($urandom_range(0, 9))
      0:       return open_mark;
      1:       return close_mark;
      2:       return escape_byte;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  task automatic queue_frame(input int unsigned len, input bit closed);
    logic [BYTE_W-1:0] b;
    queue_byte(open_mark);
    for (int unsigned i = 0; i < len; i++) begin
      b = content_byte();
      if (b == open_mark || b == close_mark || b == escape_byte
          || $urandom_range(0, 9) == 0) begin
        queue_byte(escape_byte);
      end
      queue_byte(b);
    end
    if (closed) begin
      queue_byte(close_mark);
    end
  endtask

  task automatic random_traffic(input int unsigned quota);
    int unsigned goal;
    goal = bytes_planned + quota;
    while (bytes_planned < goal) begin
      if ($urandom_range(0, 59) == 0) begin
        queue_frame($urandom_range(EFR_MAX_PAYLOAD - 2, EFR_MAX_PAYLOAD + 3),
                    $urandom_range(0, 1));
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            repeat ($urandom_range(1, 4)) queue_byte(BYTE_W'($urandom));
          end
          1, 2: queue_frame($urandom_range(0, 8), 1'b0);
          3: begin
            queue_frame($urandom_range(0, 6), 1'b0);
            queue_byte(escape_byte);
            queue_byte(close_mark);
          end
          default: queue_frame($urandom_range(0, 12), 1'b1);
        endcase
      end
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] opening[];
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    opening = '{8'h00, escape_byte, close_mark,
                open_mark, 8'h00, 8'hFF, escape_byte, open_mark, escape_byte, close_mark,
                escape_byte, escape_byte, close_mark,
                open_mark, close_mark,
                open_mark, 8'hA5, open_mark, 8'h5A, escape_byte, 8'h00, close_mark};
    foreach (opening[i]) queue_byte(opening[i]);
    random_traffic(200);
    settle();

    write_reg(CFG_START_MARKER, 8'h00);
    write_reg(CFG_STOP_MARKER, 8'hFF);
    write_reg(CFG_ESCAPE_MARKER, 8'h80);
    queue_frame(EFR_MAX_PAYLOAD, 1'b1);
    queue_frame(EFR_MAX_PAYLOAD + 2, 1'b1);
    random_traffic(150);
    settle();

    write_reg(CFG_UNMAPPED, BYTE_W'($urandom));
    write_reg(CFG_START_MARKER, 8'h3C);
    write_reg(CFG_STOP_MARKER, 8'h3C);
    write_reg(CFG_ESCAPE_MARKER, 8'h3C);
    random_traffic(130);
    settle();

    write_reg(CFG_START_MARKER, 8'h10);
    write_reg(CFG_STOP_MARKER, 8'h11);
    write_reg(CFG_ESCAPE_MARKER, 8'h10);
    random_traffic(130);
    settle();

    write_reg(CFG_START_MARKER, 8'h00);
    write_reg(CFG_STOP_MARKER, 8'hFF);
    write_reg(CFG_ESCAPE_MARKER, 8'hFF);
    random_traffic(130);
    settle();

    repeat (2) begin
      write_reg(CFG_START_MARKER, BYTE_W'($urandom));
      write_reg(CFG_STOP_MARKER, BYTE_W'($urandom));
      write_reg(CFG_ESCAPE_MARKER, BYTE_W'($urandom));
      random_traffic(130);
      settle();
    end

    write_reg(CFG_START_MARKER, START_MARKER_RST);
    write_reg(CFG_STOP_MARKER, STOP_MARKER_RST);
    write_reg(CFG_ESCAPE_MARKER, ESCAPE_MARKER_RST);
    random_traffic(80);
    settle();
    random_traffic(80);
    settle();

    if (mismatches == 0) begin
      $display("escaped_frame_receiver_top regression: pass");
    end else begin
      $display("escaped_frame_receiver_top regression: fail");
    end
    $finish;
  end

endmodule
